FILE: rtl/core/rsd_pkg.sv
// shared constants, types and gf(256) arithmetic for the reed-solomon decoder
package rsd_pkg;

  localparam int MAX_T       = 16;
  localparam int SYMBOL_BITS = 8;
  localparam int STORE_DEPTH = 255;
  localparam int NSYN        = 2 * MAX_T;
  localparam int T_W         = $clog2(MAX_T + 1);
  localparam int LEN_W       = $clog2(NSYN + 1);
  localparam int SYN_IW      = $clog2(NSYN);
  localparam int POLY_IW     = $clog2(MAX_T + 1);
  localparam int LOC_IW      = (MAX_T > 1) ? $clog2(MAX_T) : 1;
  localparam int POS_W       = 8;
  localparam int CNT_W       = 5;
  localparam int STAT_W      = 2;
  localparam int CFG_T_W     = 5;
  localparam int CFG_N_W     = 8;
  localparam int CFG_W       = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_IW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SYMBOL_BITS:0] FIELD_POLY = 9'h11D;

  localparam logic [CFG_IDX_W-1:0] CFG_T_IDX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_N_IDX = 1'b1;

  typedef logic [SYMBOL_BITS-1:0] sym_t;
  typedef sym_t gf_tab_t [256];

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FIXED = 2'd1,
    ST_FAIL  = 2'd2
  } dec_status_t;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_DECODE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] pos;
    sym_t             sym;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t item;
  } q_head_t;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_RD,
    BK_SYN_INIT,
    BK_SYN,
    BK_SYN_CHK,
    BK_BM_D0,
    BK_BM_DI,
    BK_BM_CHK,
    BK_BM_COEF,
    BK_BM_UPD,
    BK_BM_END,
    BK_CH,
    BK_CH_END,
    BK_OM,
    BK_FY_INIT,
    BK_FY_X2,
    BK_FY_H,
    BK_FY_INV,
    BK_FY_VAL,
    BK_COR_RD,
    BK_COR_WR
  } bk_state_t;

  function automatic sym_t gf_mul(sym_t a, sym_t b);
    sym_t acc;
    sym_t sh;
    acc = '0;
    sh  = a;
    for (int k = 0; k < SYMBOL_BITS; k++) begin
      if (b[k]) acc ^= sh;
      sh = {sh[SYMBOL_BITS-2:0], 1'b0} ^ (sh[SYMBOL_BITS-1] ? FIELD_POLY[SYMBOL_BITS-1:0] : '0);
    end
    return acc;
  endfunction

  function automatic gf_tab_t gen_exp();
    gf_tab_t tab;
    logic [SYMBOL_BITS:0] x;
    x = 9'd1;
    for (int k = 0; k < 255; k++) begin
      tab[k] = x[SYMBOL_BITS-1:0];
      x = x << 1;
      if (x[SYMBOL_BITS]) x ^= FIELD_POLY;
    end
    tab[255] = 8'd1;
    return tab;
  endfunction

  function automatic gf_tab_t gen_inv();
    gf_tab_t ex;
    gf_tab_t lg;
    gf_tab_t inv;
    ex = gen_exp();
    for (int k = 0; k < 256; k++) lg[k] = '0;
    for (int k = 0; k < 255; k++) lg[ex[k]] = 8'(k);
    inv[0] = '0;
    for (int a = 1; a < 256; a++) inv[a] = ex[8'd255 - lg[a]];
    return inv;
  endfunction

  localparam gf_tab_t GF_EXP = gen_exp();
  localparam gf_tab_t GF_INV = gen_inv();

endpackage

FILE: rtl/core/rsd_ram.sv
// generic single-write, single-read ram with registered read data
module rsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 255
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we && (int'(waddr) < DEPTH)) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/rsd_front.sv
// command front end: classifies transactions and queues them for the decode engine
module rsd_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_req_type,
  input  logic [rsd_pkg::POS_W-1:0] in_position,
  input  rsd_pkg::sym_t          in_symbol,
  input  logic                   in_last,
  input  logic                   pop,
  output rsd_pkg::q_head_t       head
);
  import rsd_pkg::*;

  q_entry_t         q_r [QUEUE_DEPTH];
  logic [Q_IW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_IW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]  cnt_r, cnt_nxt;
  logic             push;
  q_entry_t         entry;

  assign busy = (cnt_r == Q_CW'(QUEUE_DEPTH));
  assign push = start && !busy;

  // classify the command
  always_comb begin
    entry.pos = in_position;
    entry.sym = in_symbol;
    if (in_req_type)  entry.op = OP_READ;
    else if (in_last) entry.op = OP_DECODE;
    else              entry.op = OP_STORE;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_IW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + Q_IW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_IW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + Q_IW'(1);
    end
    if (push && !pop)      cnt_nxt = cnt_r + Q_CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - Q_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= entry;
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rd_ptr_r];

endmodule

FILE: rtl/core/rsd_back.sv
// decode engine: codeword store, syndromes, berlekamp-massey, chien, forney, correction
module rsd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rsd_pkg::CFG_T_W-1:0] cfg_t,
  input  logic [rsd_pkg::CFG_N_W-1:0] cfg_n,
  input  rsd_pkg::q_head_t            head,
  output logic                        pop,
  output logic                        out_strobe,
  output logic [rsd_pkg::STAT_W-1:0]  out_status,
  output logic [rsd_pkg::CNT_W-1:0]   out_error_count,
  output rsd_pkg::sym_t               out_corrected_symbol,
  output logic [rsd_pkg::POS_W-1:0]   out_position_out
);
  import rsd_pkg::*;

  bk_state_t         state_r, state_nxt;
  logic [T_W-1:0]    t_r, t_nxt;
  logic [POS_W-1:0]  n_r, n_nxt;
  logic [LEN_W-1:0]  nsyn_r, nsyn_nxt;
  logic [POS_W-1:0]  p_r, p_nxt;
  logic [POS_W-1:0]  rd_pos_r, rd_pos_nxt;
  sym_t              syn_r [NSYN];
  sym_t              syn_nxt [NSYN];
  sym_t              c_r [MAX_T+1];
  sym_t              c_nxt [MAX_T+1];
  sym_t              bs_r [MAX_T+1];
  sym_t              bs_nxt [MAX_T+1];
  sym_t              term_r [MAX_T+1];
  sym_t              term_nxt [MAX_T+1];
  logic [POS_W-1:0]  loc_r [MAX_T];
  logic [POS_W-1:0]  loc_nxt [MAX_T];
  sym_t              om_r [MAX_T];
  sym_t              om_nxt [MAX_T];
  sym_t              val_r [MAX_T];
  sym_t              val_nxt [MAX_T];
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  r_r, r_nxt;
  logic [LEN_W-1:0]  i_r, i_nxt;
  logic [LEN_W-1:0]  j_r, j_nxt;
  sym_t              d_r, d_nxt;
  sym_t              bb_r, bb_nxt;
  sym_t              binv_r, binv_nxt;
  sym_t              coef_r, coef_nxt;
  sym_t              x_r, x_nxt;
  sym_t              x2_r, x2_nxt;
  sym_t              num_r, num_nxt;
  sym_t              den_r, den_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;
  logic              fail_r, fail_nxt;
  logic [CNT_W-1:0]  nz_r, nz_nxt;
  dec_status_t       stat_r, stat_nxt;
  logic [CNT_W-1:0]  ecnt_r, ecnt_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  dec_status_t       out_status_r, out_status_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;
  sym_t              out_sym_r, out_sym_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;

  logic              ram_we;
  logic [POS_W-1:0]  ram_waddr, ram_raddr;
  sym_t              ram_wdata, ram_rdata;

  logic [T_W-1:0]    t_eff;
  logic [POS_W-1:0]  n_eff;
  sym_t              syn_upd [NSYN];
  sym_t              c_upd [MAX_T+1];
  sym_t              term_upd [MAX_T+1];
  logic              syn_any;
  sym_t              ch_eval;
  logic              bm_last;
  sym_t              c_at_i;
  sym_t              om_acc;
  logic              emit_dec;
  dec_status_t       fin_stat;
  logic [CNT_W-1:0]  fin_cnt;

  rsd_ram #(
    .WIDTH (SYMBOL_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pop = (state_r == BK_IDLE) && head.valid;

  // clamp capability and length
  always_comb begin
    if (cfg_t == '0)               t_eff = T_W'(1);
    else if (int'(cfg_t) > MAX_T)  t_eff = T_W'(MAX_T);
    else                           t_eff = T_W'(cfg_t);
    if (int'(cfg_n) < 2 * int'(t_eff) + 1) n_eff = POS_W'(2 * int'(t_eff) + 1);
    else                                   n_eff = cfg_n;
  end

  // per-lane arithmetic
  always_comb begin
    for (int i = 0; i < NSYN; i++) syn_upd[i] = gf_mul(syn_r[i], GF_EXP[8'(i + 1)]) ^ ram_rdata;
    for (int k = 0; k <= MAX_T; k++) begin
      c_upd[k]    = c_r[k] ^ gf_mul(coef_r, bs_r[k]);
      term_upd[k] = gf_mul(term_r[k], GF_EXP[8'(255 - k)]);
    end
    syn_any = 1'b0;
    for (int i = 0; i < NSYN; i++) begin
      if ((LEN_W'(i) < nsyn_r) && (syn_r[i] != '0)) syn_any = 1'b1;
    end
    ch_eval = '0;
    for (int k = 0; k <= MAX_T; k++) ch_eval ^= term_r[k];
  end

  assign bm_last = ((r_r + LEN_W'(1)) == nsyn_r);
  assign c_at_i  = (i_r <= LEN_W'(MAX_T)) ? c_r[i_r[POLY_IW-1:0]] : '0;
  assign om_acc  = d_r ^ gf_mul(c_r[j_r[POLY_IW-1:0]], syn_r[SYN_IW'(i_r - j_r)]);

  always_comb begin
    state_nxt  = state_r;
    t_nxt      = t_r;
    n_nxt      = n_r;
    nsyn_nxt   = nsyn_r;
    p_nxt      = p_r;
    rd_pos_nxt = rd_pos_r;
    syn_nxt    = syn_r;
    c_nxt      = c_r;
    bs_nxt     = bs_r;
    term_nxt   = term_r;
    loc_nxt    = loc_r;
    om_nxt     = om_r;
    val_nxt    = val_r;
    len_nxt    = len_r;
    r_nxt      = r_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    d_nxt      = d_r;
    bb_nxt     = bb_r;
    binv_nxt   = binv_r;
    coef_nxt   = coef_r;
    x_nxt      = x_r;
    x2_nxt     = x2_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    cnt_nxt    = cnt_r;
    fail_nxt   = fail_r;
    nz_nxt     = nz_r;
    stat_nxt   = stat_r;
    ecnt_nxt   = ecnt_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_sym_nxt    = out_sym_r;
    out_pos_nxt    = out_pos_r;
    ram_we    = 1'b0;
    ram_waddr = head.item.pos;
    ram_wdata = head.item.sym;
    ram_raddr = '0;
    emit_dec  = 1'b0;
    fin_stat  = ST_FAIL;
    fin_cnt   = '0;

    unique case (state_r)
      BK_IDLE: begin
        if (head.valid) begin
          unique case (head.item.op)
            OP_READ: begin
              ram_raddr  = head.item.pos;
              rd_pos_nxt = head.item.pos;
              state_nxt  = BK_RD;
            end
            OP_STORE: begin
              ram_we = (int'(head.item.pos) < STORE_DEPTH);
            end
            OP_DECODE: begin
              ram_we    = (int'(head.item.pos) < STORE_DEPTH);
              state_nxt = BK_SYN_INIT;
            end
            default: ;
          endcase
        end
      end
      BK_RD: begin
        out_strobe_nxt = 1'b1;
        out_status_nxt = stat_r;
        out_count_nxt  = ecnt_r;
        out_sym_nxt    = (int'(rd_pos_r) < STORE_DEPTH) ? ram_rdata : '0;
        out_pos_nxt    = rd_pos_r;
        state_nxt      = BK_IDLE;
      end
      BK_SYN_INIT: begin
        t_nxt     = t_eff;
        nsyn_nxt  = LEN_W'({t_eff, 1'b0});
        n_nxt     = n_eff;
        p_nxt     = n_eff - POS_W'(1);
        ram_raddr = n_eff - POS_W'(1);
        for (int i = 0; i < NSYN; i++) syn_nxt[i] = '0;
        state_nxt = BK_SYN;
      end
      BK_SYN: begin
        syn_nxt = syn_upd;
        if (p_r == '0) begin
          state_nxt = BK_SYN_CHK;
        end else begin
          p_nxt     = p_r - POS_W'(1);
          ram_raddr = p_r - POS_W'(1);
        end
      end
      BK_SYN_CHK: begin
        if (!syn_any) begin
          emit_dec = 1'b1;
          fin_stat = ST_OK;
        end else begin
          for (int k = 0; k <= MAX_T; k++) begin
            c_nxt[k]  = '0;
            bs_nxt[k] = '0;
          end
          c_nxt[0]  = 8'd1;
          bs_nxt[1] = 8'd1;
          len_nxt   = '0;
          bb_nxt    = 8'd1;
          r_nxt     = '0;
          state_nxt = BK_BM_D0;
        end
      end
      BK_BM_D0: begin
        d_nxt     = syn_r[r_r[SYN_IW-1:0]];
        i_nxt     = LEN_W'(1);
        state_nxt = BK_BM_DI;
      end
      BK_BM_DI: begin
        if ((i_r <= len_r) && (i_r <= r_r)) begin
          d_nxt = d_r ^ gf_mul(c_at_i, syn_r[SYN_IW'(r_r - i_r)]);
          i_nxt = i_r + LEN_W'(1);
        end else begin
          state_nxt = BK_BM_CHK;
        end
      end
      BK_BM_CHK: begin
        if (d_r == '0) begin
          bs_nxt[0] = '0;
          for (int k = 1; k <= MAX_T; k++) bs_nxt[k] = bs_r[k-1];
          r_nxt     = r_r + LEN_W'(1);
          state_nxt = bm_last ? BK_BM_END : BK_BM_D0;
        end else begin
          binv_nxt  = GF_INV[bb_r];
          state_nxt = BK_BM_COEF;
        end
      end
      BK_BM_COEF: begin
        coef_nxt  = gf_mul(d_r, binv_r);
        state_nxt = BK_BM_UPD;
      end
      BK_BM_UPD: begin
        c_nxt     = c_upd;
        bs_nxt[0] = '0;
        if ({len_r, 1'b0} <= {1'b0, r_r}) begin
          len_nxt = r_r + LEN_W'(1) - len_r;
          bb_nxt  = d_r;
          for (int k = 1; k <= MAX_T; k++) bs_nxt[k] = c_r[k-1];
        end else begin
          for (int k = 1; k <= MAX_T; k++) bs_nxt[k] = bs_r[k-1];
        end
        r_nxt     = r_r + LEN_W'(1);
        state_nxt = bm_last ? BK_BM_END : BK_BM_D0;
      end
      BK_BM_END: begin
        if (len_r > LEN_W'(t_r)) begin
          emit_dec = 1'b1;
        end else begin
          for (int k = 0; k <= MAX_T; k++) term_nxt[k] = (LEN_W'(k) <= len_r) ? c_r[k] : '0;
          p_nxt     = '0;
          cnt_nxt   = '0;
          fail_nxt  = 1'b0;
          state_nxt = BK_CH;
        end
      end
      BK_CH: begin
        if (ch_eval == '0) begin
          if ((p_r >= n_r) || (cnt_r >= POS_W'(len_r))) fail_nxt = 1'b1;
          else loc_nxt[cnt_r[LOC_IW-1:0]] = p_r;
          cnt_nxt = cnt_r + POS_W'(1);
        end
        term_nxt = term_upd;
        if (int'(p_r) == STORE_DEPTH - 1) state_nxt = BK_CH_END;
        else p_nxt = p_r + POS_W'(1);
      end
      BK_CH_END: begin
        if (fail_r || (cnt_r != POS_W'(len_r))) begin
          emit_dec = 1'b1;
        end else begin
          i_nxt     = '0;
          j_nxt     = '0;
          d_nxt     = '0;
          state_nxt = BK_OM;
        end
      end
      BK_OM: begin
        if (j_r == i_r) begin
          om_nxt[i_r[LOC_IW-1:0]] = om_acc;
          d_nxt = '0;
          j_nxt = '0;
          if ((i_r + LEN_W'(1)) == len_r) begin
            i_nxt     = '0;
            state_nxt = BK_FY_INIT;
          end else begin
            i_nxt = i_r + LEN_W'(1);
          end
        end else begin
          d_nxt = om_acc;
          j_nxt = j_r + LEN_W'(1);
        end
      end
      BK_FY_INIT: begin
        x_nxt     = GF_EXP[8'd255 - loc_r[i_r[LOC_IW-1:0]]];
        state_nxt = BK_FY_X2;
      end
      BK_FY_X2: begin
        x2_nxt    = gf_mul(x_r, x_r);
        num_nxt   = '0;
        den_nxt   = '0;
        j_nxt     = len_r;
        state_nxt = BK_FY_H;
      end
      BK_FY_H: begin
        if (j_r < len_r) num_nxt = gf_mul(num_r, x_r) ^ om_r[j_r[LOC_IW-1:0]];
        if (j_r[0])      den_nxt = gf_mul(den_r, x2_r) ^ c_r[j_r[POLY_IW-1:0]];
        if (j_r == '0) state_nxt = BK_FY_INV;
        else           j_nxt = j_r - LEN_W'(1);
      end
      BK_FY_INV: begin
        if (den_r == '0) begin
          emit_dec = 1'b1;
        end else begin
          binv_nxt  = GF_INV[den_r];
          state_nxt = BK_FY_VAL;
        end
      end
      BK_FY_VAL: begin
        val_nxt[i_r[LOC_IW-1:0]] = gf_mul(num_r, binv_r);
        if ((i_r + LEN_W'(1)) == len_r) begin
          i_nxt     = '0;
          nz_nxt    = '0;
          state_nxt = BK_COR_RD;
        end else begin
          i_nxt     = i_r + LEN_W'(1);
          state_nxt = BK_FY_INIT;
        end
      end
      BK_COR_RD: begin
        ram_raddr = loc_r[i_r[LOC_IW-1:0]];
        state_nxt = BK_COR_WR;
      end
      BK_COR_WR: begin
        ram_we    = 1'b1;
        ram_waddr = loc_r[i_r[LOC_IW-1:0]];
        ram_wdata = ram_rdata ^ val_r[i_r[LOC_IW-1:0]];
        nz_nxt    = nz_r + CNT_W'(val_r[i_r[LOC_IW-1:0]] != '0);
        if ((i_r + LEN_W'(1)) == len_r) begin
          emit_dec = 1'b1;
          fin_stat = ST_FIXED;
          fin_cnt  = nz_nxt;
        end else begin
          i_nxt     = i_r + LEN_W'(1);
          state_nxt = BK_COR_RD;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    // decode outcome, shared by every exit of the decode
    if (emit_dec) begin
      stat_nxt       = fin_stat;
      ecnt_nxt       = fin_cnt;
      out_strobe_nxt = 1'b1;
      out_status_nxt = fin_stat;
      out_count_nxt  = fin_cnt;
      out_sym_nxt    = '0;
      out_pos_nxt    = '0;
      state_nxt      = BK_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      stat_r       <= ST_OK;
      ecnt_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      stat_r       <= stat_nxt;
      ecnt_r       <= ecnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    n_r      <= n_nxt;
    nsyn_r   <= nsyn_nxt;
    p_r      <= p_nxt;
    rd_pos_r <= rd_pos_nxt;
    syn_r    <= syn_nxt;
    c_r      <= c_nxt;
    bs_r     <= bs_nxt;
    term_r   <= term_nxt;
    loc_r    <= loc_nxt;
    om_r     <= om_nxt;
    val_r    <= val_nxt;
    len_r    <= len_nxt;
    r_r      <= r_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    d_r      <= d_nxt;
    bb_r     <= bb_nxt;
    binv_r   <= binv_nxt;
    coef_r   <= coef_nxt;
    x_r      <= x_nxt;
    x2_r     <= x2_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    cnt_r    <= cnt_nxt;
    fail_r   <= fail_nxt;
    nz_r     <= nz_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_sym_r    <= out_sym_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  assign out_strobe           = out_strobe_r;
  assign out_status           = out_status_r;
  assign out_error_count      = out_count_r;
  assign out_corrected_symbol = out_sym_r;
  assign out_position_out     = out_pos_r;

endmodule

FILE: rtl/core/reed_solomon_decoder_gf256.sv
// top level of the gf(256) reed-solomon decoder
// a command is taken when start is high and busy is low; a two-entry queue
// sits between the command front end and the decode engine, so busy only
// rises when both queue entries are waiting. a load stores one symbol by
// position; a read returns the stored (corrected) symbol with the status
// and error count of the last decode. a load marked last stores its symbol
// and then decodes the word: a syndrome walk over the n code positions
// through the single read port of the codeword store, berlekamp-massey
// over 2t steps, a chien search over every field position, the evaluator,
// the error value for each located error and a read-modify-write
// correction per error; for small t the chien search and the syndrome walk
// dominate, for large t the berlekamp-massey steps do. every result is
// a one-cycle strobe on out_strobe and cannot be held off by the receiver.
// positions at or above the code length are stored but not decoded;
// position 255 is never stored and reads back as zero. the user must write
// configuration through cfg_we only while no transaction is outstanding;
// the block itself does not enforce this.
module reed_solomon_decoder_gf256 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [rsd_pkg::POS_W-1:0]     in_position,
  input  rsd_pkg::sym_t                 in_symbol,
  input  logic                          in_last,
  output logic                          out_strobe,
  output logic [rsd_pkg::STAT_W-1:0]    out_status,
  output logic [rsd_pkg::CNT_W-1:0]     out_error_count,
  output rsd_pkg::sym_t                 out_corrected_symbol,
  output logic [rsd_pkg::POS_W-1:0]     out_position_out,
  input  logic                          cfg_we,
  input  logic [rsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsd_pkg::CFG_W-1:0]     cfg_wdata
);
  import rsd_pkg::*;

  // configuration registers: correction capability and code length
  logic [CFG_T_W-1:0] cfg_t_r;
  logic [CFG_N_W-1:0] cfg_n_r;

  q_head_t head;
  logic    pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_t_r <= CFG_T_W'(MAX_T);
      cfg_n_r <= CFG_N_W'(STORE_DEPTH);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_T_IDX: cfg_t_r <= cfg_wdata[CFG_T_W-1:0];
        CFG_N_IDX: cfg_n_r <= cfg_wdata[CFG_N_W-1:0];
        default:   ;
      endcase
    end
  end

  // front end: classify and queue each command transaction
  rsd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_position (in_position),
    .in_symbol   (in_symbol),
    .in_last     (in_last),
    .pop         (pop),
    .head        (head)
  );

  // back end: store, decode and answer reads
  rsd_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_t                (cfg_t_r),
    .cfg_n                (cfg_n_r),
    .head                 (head),
    .pop                  (pop),
    .out_strobe           (out_strobe),
    .out_status           (out_status),
    .out_error_count      (out_error_count),
    .out_corrected_symbol (out_corrected_symbol),
    .out_position_out     (out_position_out)
  );

endmodule

FILE: rtl/core/rsd_checker.sv
// port-level checks on the decoder outcome, queue and reset behaviour, bound to the top level
module rsd_props (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic [rsd_pkg::STAT_W-1:0]    out_status,
  input logic [rsd_pkg::CNT_W-1:0]     out_error_count
);
  import rsd_pkg::*;

  // only a successful correction reports a nonzero count
  a_count_only_when_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ST_FIXED)) |-> (out_error_count == '0))
    else $error("nonzero error count without a correction");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (int'(out_error_count) <= MAX_T))
    else $error("error count above capability");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_strobe && !busy))
    else $error("activity right after reset");

  // the queue only fills behind an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("queue filled without a transaction");

endmodule

bind reed_solomon_decoder_gf256 rsd_props u_rsd_props (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_status      (out_status),
  .out_error_count (out_error_count)
);
